FILE: design/assert_macros.svh
// Assertion helpers for the trace profiler.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

FILE: design/ctp_pkg.sv
package ctp_pkg;

   localparam int unsigned AddrWidth = 64;
   localparam int unsigned CountWidth = 32;

   typedef enum logic [1:0] {
      CMD_REGISTER = 2'd0,
      CMD_ENTER    = 2'd1,
      CMD_EXIT     = 2'd2,
      CMD_NONE     = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      KIND_ACK    = 2'd0,
      KIND_RECORD = 2'd1,
      KIND_ERROR  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_NONE      = 3'd0,
      ERR_UNKNOWN   = 3'd1,
      ERR_FULL      = 3'd2,
      ERR_OVERFLOW  = 3'd3,
      ERR_UNDERFLOW = 3'd4
   } err_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_DECIDE,
      ST_POP_READ,
      ST_STAT_READ,
      ST_STAT_WRITE,
      ST_OUTPUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;         // capture input item
      logic search_start; // reset scan index
      logic search_step;  // compare one table entry
      logic do_register;  // append new slot
      logic do_push;      // push stack entry
      logic pop_read;     // decrement sp, read stack
      logic stat_read;    // read statistics of popped slot
      logic stat_write;   // write back updated statistics
      logic set_result;   // latch result of decide step
      logic set_record;   // latch finished call record
   } ctl_type;

   // datapath -> controller
   typedef struct packed {
      cmd_type cmd;
      logic    search_done;
      logic    found;
      logic    table_full;
      logic    stack_full;
      logic    stack_empty;
   } sts_type;

endpackage

FILE: design/ctp_datapath.sv
`include "assert_macros.svh"
module ctp_datapath #(
   parameter int unsigned TABLE_SIZE = 256,
   parameter int unsigned STACK_DEPTH = 64
) (
   input  logic              clock,
   input  logic              reset,
   input  ctp_pkg::ctl_type  ctl,
   output ctp_pkg::sts_type  sts,
   input  logic [63:0]       base_address,
   input  logic [1:0]        in_command,
   input  logic [63:0]       in_function_address,
   input  logic [63:0]       in_call_offset,
   input  logic [63:0]       in_timestamp,
   output logic [1:0]        out_record_kind,
   output logic [2:0]        out_error_code,
   output logic [7:0]        out_function_slot,
   output logic [5:0]        out_call_depth,
   output logic [63:0]       out_start_time,
   output logic [63:0]       out_end_time,
   output logic [31:0]       out_call_count,
   output logic [63:0]       out_total_time
);
   import ctp_pkg::*;

   localparam int unsigned SW = $clog2(TABLE_SIZE);
   localparam int unsigned PW = $clog2(STACK_DEPTH);

   logic [AddrWidth-1:0]  addr_mem [TABLE_SIZE];
   logic [CountWidth-1:0] cnt_mem  [TABLE_SIZE];
   logic [63:0]           tot_mem  [TABLE_SIZE];
   logic [SW-1:0]         sslot_mem[STACK_DEPTH];
   logic [63:0]           sstart_mem[STACK_DEPTH];

   logic [1:0]  cmd_ff;
   logic [63:0] key_ff, ts_ff;
   logic [SW:0] fill_ff, idx_ff;
   logic [PW:0] sp_ff;
   logic        found_ff;
   logic [SW-1:0] slot_ff;
   logic [AddrWidth-1:0] rd_addr_ff;
   logic        rd_vld_ff;
   logic [SW-1:0] pop_slot_ff;
   logic [63:0] pop_start_ff;
   logic [CountWidth-1:0] cnt_rd_ff, cnt_new;
   logic [63:0] tot_rd_ff, tot_new;

   logic [1:0]  kind_ff;
   logic [2:0]  err_ff;
   logic [7:0]  fslot_ff;
   logic [5:0]  depth_ff;
   logic [63:0] st_ff, et_ff, tot_ff;
   logic [31:0] cnt_ff;

   logic [1:0]  res_kind;
   logic [2:0]  res_err;
   logic [7:0]  res_slot;
   logic [5:0]  res_depth;
   logic [63:0] res_start;

   // table read is registered; search scans entries 0..fill-1, compare at next
   always_ff @(posedge clock) begin
      if (ctl.load) begin
         cmd_ff <= in_command;
         ts_ff  <= in_timestamp;
         key_ff <= (in_command == CMD_ENTER) ? base_address + in_call_offset
                                             : in_function_address;
      end
      rd_addr_ff <= addr_mem[idx_ff[SW-1:0]];
      if (ctl.pop_read) begin
         pop_slot_ff  <= sslot_mem[sp_ff[PW-1:0] - 1'b1];
         pop_start_ff <= sstart_mem[sp_ff[PW-1:0] - 1'b1];
      end
      if (ctl.stat_read) begin
         cnt_rd_ff <= cnt_mem[pop_slot_ff];
         tot_rd_ff <= tot_mem[pop_slot_ff];
      end
      if (ctl.do_register) begin
         addr_mem[fill_ff[SW-1:0]] <= key_ff;
         cnt_mem[fill_ff[SW-1:0]]  <= '0;
         tot_mem[fill_ff[SW-1:0]]  <= '0;
      end else if (ctl.stat_write) begin
         cnt_mem[pop_slot_ff] <= cnt_new;
         tot_mem[pop_slot_ff] <= tot_new;
      end
      if (ctl.do_push) begin
         sslot_mem[sp_ff[PW-1:0]]  <= slot_ff;
         sstart_mem[sp_ff[PW-1:0]] <= ts_ff;
      end
   end

   assign cnt_new = (cnt_rd_ff == '1) ? cnt_rd_ff : cnt_rd_ff + 1'b1;
   assign tot_new = tot_rd_ff + (ts_ff - pop_start_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff   <= '0;
         sp_ff     <= '0;
         idx_ff    <= '0;
         rd_vld_ff <= 1'b0;
         found_ff  <= 1'b0;
         slot_ff   <= '0;
      end else begin
         if (ctl.search_start) begin
            idx_ff    <= '0;
            rd_vld_ff <= 1'b0;
            found_ff  <= 1'b0;
         end else if (ctl.search_step) begin
            rd_vld_ff <= (idx_ff < fill_ff);
            if (idx_ff <= fill_ff) idx_ff <= idx_ff + 1'b1;
            if (rd_vld_ff && !found_ff && rd_addr_ff == key_ff) begin
               found_ff <= 1'b1;
               slot_ff  <= SW'(idx_ff - 1'b1);
            end
         end
         if (ctl.do_register) fill_ff <= fill_ff + 1'b1;
         if (ctl.do_push) sp_ff <= sp_ff + 1'b1;
         if (ctl.pop_read) sp_ff <= sp_ff - 1'b1;
      end
   end

   assign sts.cmd = cmd_type'(cmd_ff);
   assign sts.search_done = (idx_ff > fill_ff) || found_ff;
   assign sts.found = found_ff;
   assign sts.table_full = (fill_ff >= (SW+1)'(TABLE_SIZE));
   assign sts.stack_full = (sp_ff >= (PW+1)'(STACK_DEPTH));
   assign sts.stack_empty = (sp_ff == '0);

   // result of the decide step, fields without meaning stay zero
   always_comb begin
      res_kind  = KIND_ACK;
      res_err   = ERR_NONE;
      res_slot  = '0;
      res_depth = '0;
      res_start = '0;
      case (cmd_type'(cmd_ff))
         CMD_REGISTER: begin
            if (found_ff) res_slot = 8'(slot_ff);
            else if (sts.table_full) begin
               res_kind = KIND_ERROR; res_err = ERR_FULL;
            end else res_slot = 8'(fill_ff);
         end
         CMD_ENTER: begin
            if (!found_ff) begin
               res_kind = KIND_ERROR; res_err = ERR_UNKNOWN;
            end else if (sts.stack_full) begin
               res_kind = KIND_ERROR; res_err = ERR_OVERFLOW;
               res_slot = 8'(slot_ff);
            end else begin
               res_slot  = 8'(slot_ff);
               res_depth = 6'(sp_ff);
               res_start = ts_ff;
            end
         end
         default: begin
            res_kind = KIND_ERROR; res_err = ERR_UNDERFLOW;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.set_result) begin
         kind_ff  <= res_kind;
         err_ff   <= res_err;
         fslot_ff <= res_slot;
         depth_ff <= res_depth;
         st_ff    <= res_start;
         et_ff    <= '0;
         cnt_ff   <= '0;
         tot_ff   <= '0;
      end else if (ctl.set_record) begin
         kind_ff  <= KIND_RECORD;
         err_ff   <= ERR_NONE;
         fslot_ff <= 8'(pop_slot_ff);
         depth_ff <= 6'(sp_ff);
         st_ff    <= pop_start_ff;
         et_ff    <= ts_ff;
         cnt_ff   <= cnt_new;
         tot_ff   <= tot_new;
      end
   end

   assign out_record_kind   = kind_ff;
   assign out_error_code    = err_ff;
   assign out_function_slot = fslot_ff;
   assign out_call_depth    = depth_ff;
   assign out_start_time    = st_ff;
   assign out_end_time      = et_ff;
   assign out_call_count    = cnt_ff;
   assign out_total_time    = tot_ff;

   `ASSERT_IMPLY(a_fill_bound, clock, reset, 1'b1, fill_ff <= (SW+1)'(TABLE_SIZE))
   `ASSERT_IMPLY(a_sp_bound, clock, reset, 1'b1, sp_ff <= (PW+1)'(STACK_DEPTH))
   `ASSERT_NEXT(a_push_grows, clock, reset, ctl.do_push, sp_ff == $past(sp_ff) + 1'b1)

endmodule

FILE: design/ctp_controller.sv
`include "assert_macros.svh"
module ctp_controller (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [1:0]       req_command,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  ctp_pkg::sts_type sts,
   output ctp_pkg::ctl_type ctl
);
   import ctp_pkg::*;

   state_type state_ff, state_in;
   logic      busy;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   // output register holds result until taken
   assign busy = (state_ff == ST_OUTPUT) && !rsp_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_command == CMD_EXIT) state_in = ST_DECIDE;
               else if (req_command == CMD_NONE) state_in = ST_IDLE;
               else state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: if (sts.search_done) state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (sts.cmd == CMD_EXIT && !sts.stack_empty) state_in = ST_POP_READ;
            else state_in = ST_OUTPUT;
         end
         ST_POP_READ:   state_in = ST_STAT_READ;
         ST_STAT_READ:  state_in = ST_STAT_WRITE;
         ST_STAT_WRITE: state_in = ST_OUTPUT;
         ST_OUTPUT:     if (rsp_tready) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      ctl = '0;
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUTPUT);
      case (state_ff)
         ST_IDLE: begin
            ctl.load = req_tvalid;
            ctl.search_start = req_tvalid;
         end
         ST_SEARCH: ctl.search_step = 1'b1;
         ST_DECIDE: begin
            if (sts.cmd == CMD_EXIT && !sts.stack_empty) ctl.pop_read = 1'b1;
            else begin
               ctl.set_result = 1'b1;
               ctl.do_register = (sts.cmd == CMD_REGISTER) && !sts.found
                                 && !sts.table_full;
               ctl.do_push = (sts.cmd == CMD_ENTER) && sts.found && !sts.stack_full;
            end
         end
         ST_STAT_READ: ctl.stat_read = 1'b1;
         ST_STAT_WRITE: begin
            ctl.stat_write = 1'b1;
            ctl.set_record = 1'b1;
         end
         default: ;
      endcase
   end

   `ASSERT_IMPLY(a_no_accept_busy, clock, reset, busy, !req_tready)
   `ASSERT_NEXT(a_write_then_out, clock, reset, ctl.stat_write, rsp_tvalid)
   `ASSERT_IMPLY(a_excl, clock, reset, 1'b1, !(ctl.do_push && ctl.do_register))

endmodule

FILE: design/call_trace_profiler_core.sv
// Function-call trace profiler. Items are processed one at a time: a register
// or enter item scans the function table one slot per cycle, up to TABLE_SIZE
// slots; an exit item pops the stack and does a read-modify-write of the
// statistics, or reports underflow if the stack is empty. The result waits in
// an output register until taken; the next item is accepted after that.
`include "assert_macros.svh"
module call_trace_profiler_core #(
   parameter int unsigned TABLE_SIZE = 256,
   parameter int unsigned STACK_DEPTH = 64
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [63:0]  csr_data,     // base_address
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [1:0]   req_tuser,    // command
   input  logic [191:0] req_tdata,    // function_address, call_offset, timestamp
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [1:0]   rsp_tuser,    // record_kind
   // error_code, function_slot, call_depth, start_time, end_time,
   // call_count, total_time, zero pad
   output logic [247:0] rsp_tdata
);
   import ctp_pkg::*;

   ctl_type ctl;
   sts_type sts;
   logic [63:0] base_ff;
   logic [2:0]  err;
   logic [7:0]  fslot;
   logic [5:0]  depth;
   logic [63:0] st, et, tot;
   logic [31:0] cnt;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) base_ff <= '0;
      else if (csr_valid) base_ff <= csr_data;
   end

   ctp_controller u_ctl (
      .clock, .reset, .req_tvalid, .req_tready, .req_command(req_tuser),
      .rsp_tvalid, .rsp_tready, .sts, .ctl
   );

   ctp_datapath #(.TABLE_SIZE(TABLE_SIZE), .STACK_DEPTH(STACK_DEPTH)) u_dp (
      .clock, .reset, .ctl, .sts, .base_address(base_ff),
      .in_command(req_tuser),
      .in_function_address(req_tdata[63:0]),
      .in_call_offset(req_tdata[127:64]),
      .in_timestamp(req_tdata[191:128]),
      .out_record_kind(rsp_tuser), .out_error_code(err),
      .out_function_slot(fslot), .out_call_depth(depth),
      .out_start_time(st), .out_end_time(et),
      .out_call_count(cnt), .out_total_time(tot)
   );

   assign rsp_tdata = {7'b0000000, tot, cnt, et, st, depth, fslot, err};

   `ASSERT_IMPLY(a_rsp_kind, clock, reset, rsp_tvalid, rsp_tuser == KIND_ACK || rsp_tuser == KIND_RECORD || rsp_tuser == KIND_ERROR)
   `ASSERT_IMPLY(a_one_side, clock, reset, rsp_tvalid, !req_tready)
   `ASSERT_IMPLY(a_record_ok, clock, reset, rsp_tvalid && rsp_tuser == KIND_RECORD, err == ERR_NONE)

endmodule
